[design/utf8_stream_decoder_defines.svh]
// Shared assertion macros for the UTF-8 stream decoder.
// Every macro expects clk and rst_n to be visible where it is used.
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication.
`define U8SD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define U8SD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/u8sd_pkg.sv]
package u8sd_pkg;

    localparam int BYTE_W   = 8;
    localparam int CP_W     = 21;
    localparam int USED_W   = 3;
    localparam int FLUSH_W  = 2;

    localparam int U8SD_QUEUE_DEPTH = 4;

    localparam logic [BYTE_W-1:0] TOP2_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] TOP3_MASK  = 8'hE0;
    localparam logic [BYTE_W-1:0] TOP4_MASK  = 8'hF0;
    localparam logic [BYTE_W-1:0] TOP5_MASK  = 8'hF8;
    localparam logic [BYTE_W-1:0] CONT_CODE  = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;

    localparam logic [USED_W-1:0] LEN_NONE = 3'd0;
    localparam logic [USED_W-1:0] LEN_ONE  = 3'd1;
    localparam logic [USED_W-1:0] LEN_TWO  = 3'd2;
    localparam logic [USED_W-1:0] LEN_THREE = 3'd3;
    localparam logic [USED_W-1:0] LEN_FOUR = 3'd4;

    // One entry of the queue: what a single input byte causes.
    // First flush_n held bytes raw (lead, cont0, cont1), then an optional final result.
    typedef struct packed {
        logic [FLUSH_W-1:0] flush_n;
        logic [BYTE_W-1:0]  lead;
        logic [BYTE_W-1:0]  cont0;
        logic [BYTE_W-1:0]  cont1;
        logic               has_final;
        logic [CP_W-1:0]    fin_cp;
        logic [USED_W-1:0]  fin_used;
        logic               fin_raw;
        logic               fin_end;
    } cmd_t;

endpackage

[design/u8sd_front.sv]
module u8sd_front
    import u8sd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              q_full,
    output logic              in_stall,
    output logic              push,
    output cmd_t              push_cmd
);
`include "utf8_stream_decoder_defines.svh"

    logic [BYTE_W-1:0]  lead_reg, lead_next;
    logic [BYTE_W-1:0]  cont0_reg, cont0_next;
    logic [BYTE_W-1:0]  cont1_reg, cont1_next;
    logic [USED_W-1:0]  exp_reg, exp_next;
    logic [FLUSH_W-1:0] held_reg, held_next;

    logic accept;
    logic is_cont;
    logic fresh;
    cmd_t cmd;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign is_cont  = (in_byte & TOP2_MASK) == CONT_CODE;

    always_comb
    begin
        lead_next  = lead_reg;
        cont0_next = cont0_reg;
        cont1_next = cont1_reg;
        exp_next   = exp_reg;
        held_next  = held_reg;
        cmd        = '0;
        fresh      = 1'b1;

        if (exp_reg != LEN_NONE)
        begin
            if (is_cont)
            begin
                fresh = 1'b0;
                if (({1'b0, held_reg} + 3'd1) >= exp_reg)
                begin
                    cmd.has_final = 1'b1;
                    cmd.fin_used  = exp_reg;
                    case (exp_reg)
                        LEN_TWO:
                            cmd.fin_cp = {10'd0, lead_reg[4:0], in_byte[5:0]};
                        LEN_THREE:
                            cmd.fin_cp = {5'd0, lead_reg[3:0], cont0_reg[5:0], in_byte[5:0]};
                        default:
                            cmd.fin_cp = {lead_reg[2:0], cont0_reg[5:0], cont1_reg[5:0],
                                          in_byte[5:0]};
                    endcase
                    exp_next  = LEN_NONE;
                    held_next = '0;
                end
                else
                begin
                    if (held_reg[0])
                        cont0_next = in_byte;
                    else
                        cont1_next = in_byte;
                    held_next = held_reg + 2'd1;
                end
            end
            else
            begin
                // Missing continuation: flush what is held, then treat the byte afresh
                cmd.flush_n = held_reg;
                cmd.lead    = lead_reg;
                cmd.cont0   = cont0_reg;
                cmd.cont1   = cont1_reg;
                exp_next    = LEN_NONE;
                held_next   = '0;
            end
        end

        if (fresh)
        begin
            if (in_byte == '0)
            begin
                cmd.has_final = 1'b1;
                cmd.fin_cp    = '0;
                cmd.fin_used  = LEN_ONE;
                cmd.fin_end   = 1'b1;
            end
            else if (!in_byte[7])
            begin
                cmd.has_final = 1'b1;
                cmd.fin_cp    = {{(CP_W-BYTE_W){1'b0}}, in_byte};
                cmd.fin_used  = LEN_ONE;
            end
            else if ((in_byte & TOP3_MASK) == LEAD2_CODE)
            begin
                lead_next = in_byte;
                exp_next  = LEN_TWO;
                held_next = 2'd1;
            end
            else if ((in_byte & TOP4_MASK) == LEAD3_CODE)
            begin
                lead_next = in_byte;
                exp_next  = LEN_THREE;
                held_next = 2'd1;
            end
            else if ((in_byte & TOP5_MASK) == LEAD4_CODE)
            begin
                lead_next = in_byte;
                exp_next  = LEN_FOUR;
                held_next = 2'd1;
            end
            else
            begin
                // Stray continuation or invalid lead
                cmd.has_final = 1'b1;
                cmd.fin_cp    = {{(CP_W-BYTE_W){1'b0}}, in_byte};
                cmd.fin_used  = LEN_ONE;
                cmd.fin_raw   = 1'b1;
            end
        end
    end

    // Drop bytes that are only absorbed
    assign push     = accept && (cmd.has_final || (cmd.flush_n != '0));
    assign push_cmd = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg  <= '0;
            cont0_reg <= '0;
            cont1_reg <= '0;
            exp_reg   <= LEN_NONE;
            held_reg  <= '0;
        end
        else if (accept)
        begin
            lead_reg  <= lead_next;
            cont0_reg <= cont0_next;
            cont1_reg <= cont1_next;
            exp_reg   <= exp_next;
            held_reg  <= held_next;
        end
    end

    `U8SD_ASSERT_IMPL(a_idle_holds_nothing, exp_reg == LEN_NONE, held_reg == '0,
        "held bytes without a pending sequence")
    `U8SD_ASSERT_IMPL(a_pending_consistent, exp_reg != LEN_NONE,
        (held_reg != '0) && ({1'b0, held_reg} < exp_reg),
        "held byte count out of step with expected length")

endmodule

[design/u8sd_queue.sv]
module u8sd_queue
    import u8sd_pkg::*;
#(
    parameter int DEPTH = U8SD_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output cmd_t head
);
`include "utf8_stream_decoder_defines.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = count_reg == FULL_CNT;
    assign head_valid = count_reg != '0;
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `U8SD_ASSERT_IMPL(a_no_overflow, push, !full || pop, "push into a full queue")
    `U8SD_ASSERT_IMPL(a_no_underflow, pop, head_valid, "pop from an empty queue")

endmodule

[design/u8sd_back.sv]
module u8sd_back
    import u8sd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  cmd_t              head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CP_W-1:0]   code_point,
    output logic [USED_W-1:0] bytes_used,
    output logic              is_raw,
    output logic              is_end,
    output logic              last_of_run
);
`include "utf8_stream_decoder_defines.svh"

    logic [FLUSH_W-1:0] step_reg, step_next;
    logic               out_valid_reg, out_valid_next;
    logic [CP_W-1:0]    cp_reg;
    logic [USED_W-1:0]  used_reg;
    logic               raw_reg;
    logic               end_reg;
    logic               last_reg;

    logic [USED_W-1:0]  total;
    logic               last;
    logic               load;
    logic [BYTE_W-1:0]  flush_byte;
    logic               in_flush;

    assign total    = {1'b0, head.flush_n} + {2'b00, head.has_final};
    assign last     = ({1'b0, step_reg} + 3'd1) == total;
    assign load     = head_valid && (!out_valid_reg || !out_stall);
    assign pop      = load && last;
    assign in_flush = step_reg < head.flush_n;

    always_comb
    begin
        case (step_reg)
            2'd0:    flush_byte = head.lead;
            2'd1:    flush_byte = head.cont0;
            default: flush_byte = head.cont1;
        endcase
    end

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            step_next      = last ? '0 : step_reg + 2'd1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            last_reg <= last;
            if (in_flush)
            begin
                cp_reg   <= {{(CP_W-BYTE_W){1'b0}}, flush_byte};
                used_reg <= LEN_ONE;
                raw_reg  <= 1'b1;
                end_reg  <= 1'b0;
            end
            else
            begin
                cp_reg   <= head.fin_cp;
                used_reg <= head.fin_used;
                raw_reg  <= head.fin_raw;
                end_reg  <= head.fin_end;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign code_point  = cp_reg;
    assign bytes_used  = used_reg;
    assign is_raw      = raw_reg;
    assign is_end      = end_reg;
    assign last_of_run = last_reg;

    `U8SD_ASSERT_IMPL(a_step_in_range, head_valid, ({1'b0, step_reg} < total),
        "result step beyond the entry's result count")
    `U8SD_ASSERT_NEXT(a_load_shows, load, out_valid, "loaded result not presented")

endmodule

[design/utf8_stream_decoder.sv]
// UTF-8 stream decoder.
// Input channel: in_valid / in_stall / in_byte, one text byte per transaction;
// a zero byte ends the text. Output channel: out_valid / out_stall with
// code_point, bytes_used, is_raw, is_end and last_of_run, one result per transaction.
// A byte is accepted on any edge where in_valid is high and in_stall low; the
// front end decodes it in that cycle and writes what it causes (0 to 4 results)
// into a QUEUE_DEPTH-entry queue. Bytes that are only absorbed into a pending
// sequence write nothing.
// Results are written by the front end into the queue, and the back end then loads
// them from the queue head into the output register, which presents them.
// Throughput: one byte per cycle while each byte causes at most one result and
// the receiver does not stall; a byte that causes several results has them
// presented one after another by the single output register. in_stall is high
// exactly when the queue is full. When the receiver holds out_stall, the output
// transaction holds, the queue fills and the input then stalls; nothing is lost.
// Reset (rst_n, asynchronous) empties the queue and drops any pending sequence.
module utf8_stream_decoder
    import u8sd_pkg::*;
#(
    parameter int QUEUE_DEPTH = U8SD_QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] in_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CP_W-1:0]   code_point,
    output logic [USED_W-1:0] bytes_used,
    output logic              is_raw,
    output logic              is_end,
    output logic              last_of_run
);

    logic q_full;
    logic push;
    cmd_t push_cmd;
    logic pop;
    logic head_valid;
    cmd_t head;

    u8sd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_byte  (in_byte),
        .q_full   (q_full),
        .in_stall (in_stall),
        .push     (push),
        .push_cmd (push_cmd)
    );

    u8sd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head)
    );

    u8sd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .code_point  (code_point),
        .bytes_used  (bytes_used),
        .is_raw      (is_raw),
        .is_end      (is_end),
        .last_of_run (last_of_run)
    );

endmodule
